### sv/efcd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the escaped frame CRC32 deframer.
// No dependencies; imported by every module of the block.
package efcd_pkg;

  localparam logic [7:0] END_BYTE    = 8'hFF;
  localparam logic [7:0] ESC_BYTE    = 8'hFE;
  localparam logic [7:0] ESC_END_SEQ = 8'hFD;  // escaped form of 0xFF
  localparam logic [7:0] ESC_ESC_SEQ = 8'hFC;  // escaped form of 0xFE

  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_XOUT = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_LEN_ERR  = 2'd1,
    STATUS_CRC_ERR  = 2'd2,
    STATUS_OVERFLOW = 2'd3
  } efcd_status_t;

  typedef struct packed {
    logic         emit;
    logic [7:0]   data;
    logic         last;
    efcd_status_t status;
  } efcd_result_t;

endpackage

### sv/efcd_crc32_byte.sv
`timescale 1ns / 1ps
// One-byte update of the reflected CRC32 (XOR network, no state).
// Depends on efcd_pkg for the polynomial.
module efcd_crc32_byte
  import efcd_pkg::*;
(
  input  logic [31:0] crc_in,
  input  logic [7:0]  data,
  output logic [31:0] crc_out
);

  always_comb begin
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    crc_out = c;
  end

endmodule

### sv/efcd_frame_ctrl.sv
`timescale 1ns / 1ps
// Frame state: unescape, header capture, running CRC and end-of-frame verdict.
// Depends on efcd_pkg and efcd_crc32_byte.
module efcd_frame_ctrl
  import efcd_pkg::*;
#(
  parameter int MAX_FRAME = 256
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         advance,
  input  logic [7:0]   byte_in,
  output efcd_result_t result
);

  localparam int CNT_W = $clog2(MAX_FRAME + 1);

  logic             skip_first, skip_first_next;
  logic             escape_pending, escape_pending_next;
  logic [CNT_W-1:0] count, count_next;
  logic             overflow_seen, overflow_seen_next;
  logic [31:0]      length_word, length_word_next;
  logic [31:0]      crc_word, crc_word_next;
  logic [31:0]      running_crc, running_crc_next;
  logic [31:0]      crc_updated;
  logic [7:0]       value;
  logic             have_value;
  logic             len_ok;

  efcd_crc32_byte u_crc (
    .crc_in  (running_crc),
    .data    (value),
    .crc_out (crc_updated)
  );

  assign len_ok = (count >= CNT_W'(8)) && (length_word == (32'(count) - 32'd8));

  always_comb begin
    skip_first_next     = skip_first;
    escape_pending_next = escape_pending;
    count_next          = count;
    overflow_seen_next  = overflow_seen;
    length_word_next    = length_word;
    crc_word_next       = crc_word;
    running_crc_next    = running_crc;
    result              = '{emit: 1'b0, data: 8'd0, last: 1'b0, status: STATUS_OK};
    value               = byte_in;
    have_value          = 1'b0;

    // Unescape
    if (escape_pending) begin
      unique case (byte_in)
        ESC_END_SEQ: value = END_BYTE;
        ESC_ESC_SEQ: value = ESC_BYTE;
        default:     value = 8'd0;
      endcase
    end

    if (advance) begin
      priority if (byte_in == END_BYTE) begin
        result.emit = 1'b1;
        result.last = 1'b1;
        priority if (overflow_seen) result.status = STATUS_OVERFLOW;
        else if (!len_ok)           result.status = STATUS_LEN_ERR;
        else if ((running_crc ^ CRC_XOUT) != crc_word) result.status = STATUS_CRC_ERR;
        else                        result.status = STATUS_OK;
        skip_first_next     = 1'b1;
        escape_pending_next = 1'b0;
        count_next          = '0;
        overflow_seen_next  = 1'b0;
        length_word_next    = '0;
        crc_word_next       = '0;
        running_crc_next    = CRC_INIT;
      end else if (skip_first) begin
        skip_first_next = 1'b0;
      end else if (escape_pending) begin
        escape_pending_next = 1'b0;
        have_value          = 1'b1;
      end else if (byte_in == ESC_BYTE) begin
        escape_pending_next = 1'b1;
      end else begin
        have_value = 1'b1;
      end

      if (have_value) begin
        priority if (count >= CNT_W'(MAX_FRAME)) begin
          overflow_seen_next = 1'b1;
        end else if (count < CNT_W'(4)) begin
          length_word_next[8*count[1:0] +: 8] = value;
          count_next = count + 1'b1;
        end else if (count < CNT_W'(8)) begin
          crc_word_next[8*count[1:0] +: 8] = value;
          count_next = count + 1'b1;
        end else begin
          count_next       = count + 1'b1;
          running_crc_next = crc_updated;
          result.emit      = 1'b1;
          result.data      = value;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      skip_first     <= 1'b1;
      escape_pending <= 1'b0;
      count          <= '0;
      overflow_seen  <= 1'b0;
      length_word    <= '0;
      crc_word       <= '0;
      running_crc    <= CRC_INIT;
    end else begin
      skip_first     <= skip_first_next;
      escape_pending <= escape_pending_next;
      count          <= count_next;
      overflow_seen  <= overflow_seen_next;
      length_word    <= length_word_next;
      crc_word       <= crc_word_next;
      running_crc    <= running_crc_next;
    end
  end

endmodule

### sv/escaped_frame_crc32_deframer.sv
`timescale 1ns / 1ps
// Top level of the escaped frame CRC32 deframer: input register, frame
// control, output register. Depends on efcd_pkg and efcd_frame_ctrl.
//
//   channel | dir | handshake          | payload
//   --------+-----+--------------------+-----------------------------------
//   s_*     | in  | s_tvalid/s_tready  | s_tdata[7:0] = in_byte
//   m_*     | out | m_tvalid/m_tready  | m_tdata[7:0] = out_byte,
//           |     |                    | m_tlast = frame_end,
//           |     |                    | m_tuser[1:0] = status
//
// One raw byte is accepted per cycle when the output side keeps up; each
// request lands in the input register, is decoded through one pass of
// unescape/header capture/CRC32 byte update, and its result (if any) is
// loaded into the output register as it advances. Stalls on m_tready
// hold the output register, then the input register; s_tready drops only
// when both are full. Synchronous reset clears frame state to "expect a
// dropped first byte" and empties both registers.
module escaped_frame_crc32_deframer
  import efcd_pkg::*;
#(
  parameter int MAX_FRAME = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] in_byte
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast,
  output logic [1:0] m_tuser    // [1:0] status
);

  logic         in_valid;
  logic [7:0]   in_byte;
  logic         advance;
  efcd_result_t result;

  logic         out_valid;
  logic [7:0]   out_byte;
  logic         out_last;
  efcd_status_t out_status;

  // Advance the held request whenever the output slot is free or draining.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  efcd_frame_ctrl #(
    .MAX_FRAME (MAX_FRAME)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .byte_in (in_byte),
    .result  (result)
  );

  // Load a result when the request advances; drop the valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= result.emit;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.emit) begin
      out_byte   <= result.data;
      out_last   <= result.last;
      out_status <= result.status;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_byte;
  assign m_tlast  = out_last;
  assign m_tuser  = out_status;

endmodule
